// File: hdl/bmpb_pkg.sv
// Shared types and codes for the bicolour matrix pixel buffer.
// No dependencies; used by the command and byte interfaces, controller, datapath and top level.

package bmpb_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned BYTE_W  = 8;

    typedef enum logic [1:0] {
        OP_DRAW  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        COL_OFF    = 2'd0,
        COL_GREEN  = 2'd1,
        COL_RED    = 2'd2,
        COL_YELLOW = 2'd3
    } t_color;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } t_rotation;

    localparam logic [BYTE_W-1:0] START_ADDR = 8'h00;

    // Controller to datapath
    typedef struct packed {
        logic draw;
        logic clear;
        logic emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic at_last;
    } t_status;

endpackage

// File: hdl/bmpb_cmd_if.sv
// Input channel of the pixel buffer: op, coordinates and colour.
// Depends on bmpb_pkg.

interface bmpb_cmd_if;
    import bmpb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                op;
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
    logic [1:0]                pixel_color;

    modport source (output valid, output op, output pixel_x, output pixel_y,
                    output pixel_color, input ready);
    modport sink   (input valid, input op, input pixel_x, input pixel_y,
                    input pixel_color, output ready);
endinterface

// File: hdl/bmpb_byte_if.sv
// Output channel of the pixel buffer: one flushed byte per transfer.
// Depends on bmpb_pkg.

interface bmpb_byte_if;
    import bmpb_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// File: hdl/bmpb_cfg_if.sv
// Configuration write channel: the rotation register.
// No package dependency.

interface bmpb_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] rotation;

    modport source (output valid, output rotation, input ready);
    modport sink   (input valid, input rotation, output ready);
endinterface

// File: hdl/bicolor_matrix_pixel_buffer.sv
// Frame buffer for a two-colour LED matrix of ROWS x COLUMNS pixels, one
// 16-bit word per row (green in the low byte, red in the high byte). Draw,
// clear and the unused op leave the input ready for the next item. A flush,
// once taken, holds the input until the single output register has streamed
// 2*ROWS+1 words, one word per cycle while the output is not stalled:
// the start address 0x00, then each row low byte and high byte, the final
// word marked by last. The next item can be taken in the cycle after the
// final word of a flush has entered the output register.
// Rotation is written through the configuration channel, which is always ready.
// Depends on bmpb_pkg, the three channel interfaces, bmpb_ctrl and bmpb_dpath.

module bicolor_matrix_pixel_buffer #(
    parameter int unsigned ROWS    = 8,
    parameter int unsigned COLUMNS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bmpb_cmd_if.sink    i_cmd,
    bmpb_cfg_if.sink    i_cfg,
    bmpb_byte_if.source o_byte
);
    import bmpb_pkg::*;

    t_cmd    cmd;
    t_status sts;

    bmpb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bmpb_dpath #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_pixel_x     (i_cmd.pixel_x),
        .i_pixel_y     (i_cmd.pixel_y),
        .i_pixel_color (i_cmd.pixel_color),
        .i_cfg         (i_cfg),
        .o_byte        (o_byte)
    );
endmodule

// File: hdl/bmpb_ctrl.sv
// Controller of the pixel buffer: input handshake and flush sequencing.
// Depends on bmpb_pkg and bmpb_cmd_if.

module bmpb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bmpb_cmd_if.sink         i_cmd,
    input  bmpb_pkg::t_status i_sts,
    output bmpb_pkg::t_cmd   o_cmd
);
    import bmpb_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_FLUSH
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   accept;
    t_op    op;

    assign op          = t_op'(i_cmd.op);
    assign i_cmd.ready = r_in_ready;
    assign accept      = i_cmd.valid && r_in_ready;

    always_comb begin
        o_cmd.draw  = accept && (op == OP_DRAW);
        o_cmd.clear = accept && (op == OP_CLEAR);
        o_cmd.emit  = (r_state == S_FLUSH) && i_sts.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (op == OP_FLUSH)) begin
                        r_state    <= S_FLUSH;
                        r_in_ready <= 1'b0;
                    end else begin
                        r_in_ready <= 1'b1;
                    end
                end
                S_FLUSH: begin
                    // leave once the final word is in the output register
                    if (i_sts.out_free && i_sts.at_last) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b0;
                end
            endcase
        end
    end
endmodule

// File: hdl/bmpb_dpath.sv
// Datapath of the pixel buffer: row words, rotation, pixel update and byte output.
// Depends on bmpb_pkg, bmpb_byte_if and bmpb_cfg_if.

module bmpb_dpath #(
    parameter int unsigned ROWS    = 8,
    parameter int unsigned COLUMNS = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  bmpb_pkg::t_cmd                         i_cmd,
    output bmpb_pkg::t_status                      o_sts,
    input  logic signed [bmpb_pkg::COORD_W-1:0]    i_pixel_x,
    input  logic signed [bmpb_pkg::COORD_W-1:0]    i_pixel_y,
    input  logic [1:0]                             i_pixel_color,
    bmpb_cfg_if.sink                               i_cfg,
    bmpb_byte_if.source                            o_byte
);
    import bmpb_pkg::*;

    localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned NBYTES = 2 * ROWS + 1;
    localparam int unsigned IDX_W  = $clog2(NBYTES);
    localparam int unsigned CW     = COORD_W + 1;

    localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(NBYTES - 1);
    localparam logic signed [CW-1:0] XMAX    = CW'(COLUMNS - 1);
    localparam logic signed [CW-1:0] YMAX    = CW'(ROWS - 1);

    logic [WORD_W-1:0] r_rows [ROWS];
    t_rotation         r_rotation;
    logic [IDX_W-1:0]  r_byte_idx;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_data;
    logic              r_out_last;

    // draw path
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] ry;
    logic                 in_range;
    logic                 rot_range;
    logic [4:0]           bit_pos;
    logic [WORD_W-1:0]    green;
    logic [WORD_W-1:0]    red;
    logic [ROW_W-1:0]     row_sel;
    logic [WORD_W-1:0]    cur_word;
    logic [WORD_W-1:0]    n_word;

    // flush path
    logic [IDX_W-1:0]  idx_m1;
    logic [ROW_W-1:0]  flush_row;
    logic [WORD_W-1:0] flush_word;
    logic [BYTE_W-1:0] n_out_data;

    assign x = CW'(i_pixel_x);
    assign y = CW'(i_pixel_y);

    assign in_range = (x >= 0) && (x <= XMAX) && (y >= 0) && (y <= YMAX);

    always_comb begin
        unique case (r_rotation)
            ROT_90: begin
                rx = XMAX - y;
                ry = x;
            end
            ROT_180: begin
                rx = XMAX - x;
                ry = YMAX - y;
            end
            ROT_270: begin
                rx = y;
                ry = YMAX - x;
            end
            default: begin
                rx = x;
                ry = y;
            end
        endcase
    end

    // only bites on a matrix that is not square
    assign rot_range = (rx >= 0) && (rx <= XMAX) && (ry >= 0) && (ry <= YMAX);

    assign bit_pos  = rx[4:0];
    assign green    = WORD_W'(1) << bit_pos;
    assign red      = WORD_W'(1) << (bit_pos + 5'd8);
    assign row_sel  = ry[ROW_W-1:0];
    assign cur_word = r_rows[row_sel];

    always_comb begin
        unique case (t_color'(i_pixel_color))
            COL_GREEN:  n_word = (cur_word | green) & ~red;
            COL_RED:    n_word = (cur_word | red) & ~green;
            COL_YELLOW: n_word = cur_word | green | red;
            default:    n_word = cur_word & ~(green | red);
        endcase
    end

    // byte k>0 is row (k-1)/2, low byte on odd k
    assign idx_m1     = r_byte_idx - IDX_W'(1);
    assign flush_row  = idx_m1[ROW_W:1];
    assign flush_word = r_rows[flush_row];

    always_comb begin
        priority if (r_byte_idx == '0) begin
            n_out_data = START_ADDR;
        end else if (idx_m1[0] == 1'b0) begin
            n_out_data = flush_word[BYTE_W-1:0];
        end else begin
            n_out_data = flush_word[WORD_W-1:BYTE_W];
        end
    end

    assign o_sts.out_free = !r_out_valid || o_byte.ready;
    assign o_sts.at_last  = (r_byte_idx == LAST_IDX);

    assign i_cfg.ready     = 1'b1;
    assign o_byte.valid    = r_out_valid;
    assign o_byte.data_byte = r_out_data;
    assign o_byte.last     = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ROWS; i++) begin
                r_rows[i] <= '0;
            end
            r_rotation  <= ROT_0;
            r_byte_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_rotation <= t_rotation'(i_cfg.rotation);
            end
            if (i_cmd.clear) begin
                for (int i = 0; i < ROWS; i++) begin
                    r_rows[i] <= '0;
                end
            end else if (i_cmd.draw && in_range && rot_range) begin
                r_rows[row_sel] <= n_word;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_byte_idx  <= o_sts.at_last ? '0 : r_byte_idx + IDX_W'(1);
            end else if (o_byte.ready) begin
                // drop the word once taken
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= n_out_data;
            r_out_last <= o_sts.at_last;
        end
    end
endmodule
